### hdl/drum_step_pattern_store_top_defines.svh
// Assertion helpers shared by the pattern store RTL.
`ifndef DRUM_STEP_PATTERN_STORE_TOP_DEFINES_SVH
`define DRUM_STEP_PATTERN_STORE_TOP_DEFINES_SVH

// Check a property on every rising edge of clk_i, quiet while in reset.
`define DSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge.
`define DSPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DSPS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/dsps_pkg.sv
package dsps_pkg;

  // Default store geometry
  localparam int NumInstruments = 8;
  localparam int NumPatterns    = 64;
  localparam int StepsPerTrack  = 64;

  // Width of a step index on the bus
  localparam int StepW = 6;

  // Request kinds
  localparam logic [1:0] ReqRead    = 2'd0;
  localparam logic [1:0] ReqWrite   = 2'd1;
  localparam logic [1:0] ReqFind    = 2'd2;
  localparam logic [1:0] ReqUnknown = 2'd3;

  // Status of the find-next unit, one-cycle done pulse
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [StepW-1:0] step;
  } find_status_t;

endpackage

### hdl/dsps_find.sv
module dsps_find #(
  parameter int STEPS_PER_TRACK = dsps_pkg::StepsPerTrack
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [$clog2(STEPS_PER_TRACK)-1:0] start_step_i,
  input  logic [STEPS_PER_TRACK-1:0]   bitmap_i,
  output dsps_pkg::find_status_t       status_o
);

  localparam int SW    = $clog2(STEPS_PER_TRACK);
  localparam int NG    = (STEPS_PER_TRACK + 7) / 8;
  localparam int GW    = (NG > 1) ? $clog2(NG) : 1;
  localparam int WinW  = NG * 8;
  localparam int OffW  = GW + 3;
  localparam int SumW  = ((SW > OffW) ? SW : OffW) + 1;

  logic [2*STEPS_PER_TRACK-1:0] dbl;
  logic [2*STEPS_PER_TRACK-1:0] rot;
  logic [WinW-1:0]              win_d;
  logic [WinW-1:0]              win_q;
  logic [GW-1:0]                grp_q;
  logic [SW-1:0]                start_q;
  logic                         busy_q;
  logic                         done_q;
  logic                         hit_q;
  logic [dsps_pkg::StepW-1:0]   step_q;
  logic [7:0]                   grp_bits;
  logic [2:0]                   pos;
  logic [OffW-1:0]              offset;
  logic [SumW-1:0]              sum;
  logic [SumW-1:0]              wrapped;

  // Rotate the bitmap so the start step sits at bit 0
  always_comb begin
    dbl   = {bitmap_i, bitmap_i};
    rot   = dbl >> start_step_i;
    win_d = WinW'(rot[STEPS_PER_TRACK-1:0]);
  end

  // Pick the lowest set bit of the current group and map it back to a step
  always_comb begin
    grp_bits = win_q[{grp_q, 3'b000} +: 8];
    pos      = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_bits[i]) begin
        pos = 3'(i);
      end
    end
    offset  = {grp_q, pos};
    sum     = SumW'(start_q) + SumW'(offset);
    wrapped = (sum >= SumW'(STEPS_PER_TRACK)) ? sum - SumW'(STEPS_PER_TRACK) : sum;
  end

  // Scan one group of eight steps per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q  <= 1'b1;
        done_q  <= 1'b0;
        grp_q   <= '0;
        win_q   <= win_d;
        start_q <= start_step_i;
      end else if (busy_q) begin
        if (|grp_bits) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hit_q  <= 1'b1;
          step_q <= dsps_pkg::StepW'(wrapped);
        end else if (grp_q == GW'(NG - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          hit_q  <= 1'b0;
        end else begin
          done_q <= 1'b0;
          grp_q  <= grp_q + GW'(1);
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign status_o.done = done_q;
  assign status_o.hit  = hit_q;
  assign status_o.step = step_q;

endmodule

### hdl/drum_step_pattern_store_top.sv
// Drum step pattern store.
// Requests come in on the s_axis channel, one word each: tuser carries the
// kind (read, write, find next active step), tdata the track address, the
// step and the values to store. Every request gives exactly one result word
// on m_axis: tuser is the found flag, tdata the step and its stored bits.
// One request is handled at a time; s_axis_tready is low while it is busy.
// A write passes the read and done states, a read passes read, extract and
// done, and a find next passes read, the find unit's search of eight steps
// per cycle, extract on a hit, and done; a bad address or unknown kind goes
// straight to done. s_axis_tready rises as the result is loaded.
// Each track is one wide row of the track memory; reads and writes go
// through its single read port and a read-modify-write of that row.
// After reset a clearing pass zeroes one track row per cycle, covering all
// NUM_INSTRUMENTS * NUM_PATTERNS rows (512 by default); no request is
// accepted meanwhile.
// The result sits in an output register; if the receiver stalls, the next
// request may still be accepted, and its result waits until the register
// has been taken.
`include "drum_step_pattern_store_top_defines.svh"

module drum_step_pattern_store_top #(
  parameter int NUM_INSTRUMENTS = dsps_pkg::NumInstruments,
  parameter int NUM_PATTERNS    = dsps_pkg::NumPatterns,
  parameter int STEPS_PER_TRACK = dsps_pkg::StepsPerTrack
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instrument[2:0], pattern_index[8:3], start_step[14:9], wr_active[15],
  // wr_mute[16], wr_sub0[18:17], wr_sub1[20:19], wr_sub2[22:21],
  // wr_sub3[24:23], zero fill[31:25]
  input  logic [31:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_step[5:0], out_active[6], out_mute[7], out_sub0[9:8],
  // out_sub1[11:10], out_sub2[13:12], out_sub3[15:14]
  output logic [15:0] m_axis_tdata,
  // found[0]
  output logic [0:0]  m_axis_tuser
);

  localparam int NT   = NUM_INSTRUMENTS * NUM_PATTERNS;
  localparam int TW   = (NT > 1) ? $clog2(NT) : 1;
  localparam int S    = STEPS_PER_TRACK;
  localparam int SW   = $clog2(S);
  localparam int RowW = S * 10;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StRead,
    StFind,
    StExt,
    StDone
  } state_e;

  state_e                      state_q;
  logic [TW-1:0]               clr_cnt_q;
  logic [1:0]                  req_q;
  logic [TW-1:0]               track_q;
  logic [dsps_pkg::StepW-1:0]  step_q;
  logic                        wr_active_q;
  logic                        wr_mute_q;
  logic [7:0]                  wr_vel_q;
  logic                        res_found_q;
  logic                        res_active_q;
  logic                        res_mute_q;
  logic [7:0]                  res_vel_q;
  logic                        out_valid_q;
  logic [15:0]                 out_data_q;
  logic                        out_found_q;
  logic                        out_load;

  logic [RowW-1:0]             mem [NT];
  logic [RowW-1:0]             rd_q;

  // Unpacked request fields
  logic [1:0]                  in_req;
  logic [2:0]                  in_instr;
  logic [5:0]                  in_pat;
  logic [dsps_pkg::StepW-1:0]  in_step;
  logic                        in_accept;
  logic                        in_bad;
  logic [TW-1:0]               in_track;

  // Row slices and write-back row
  logic [S-1:0]                row_act;
  logic [S-1:0]                row_mute;
  logic [8*S-1:0]              row_vel;
  logic [S-1:0]                new_act;
  logic [S-1:0]                new_mute;
  logic [8*S-1:0]              new_vel;
  logic [SW-1:0]               idx;
  logic [SW-1:0]               find_start;

  logic                        wr_en;
  logic [TW-1:0]               wr_addr;
  logic [RowW-1:0]             wr_data;
  logic                        find_go;
  dsps_pkg::find_status_t      find_st;

  assign in_req    = s_axis_tuser;
  assign in_instr  = s_axis_tdata[2:0];
  assign in_pat    = s_axis_tdata[8:3];
  assign in_step   = s_axis_tdata[14:9];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);

  // Load the output register when it is free or being taken
  assign out_load = (state_q == StDone) && (!out_valid_q || m_axis_tready);

  // Sort out requests that touch no step
  always_comb begin
    in_bad = (in_req == dsps_pkg::ReqUnknown) ||
             (32'(in_instr) >= NUM_INSTRUMENTS) ||
             (32'(in_pat) >= NUM_PATTERNS) ||
             ((in_req != dsps_pkg::ReqFind) && (32'(in_step) >= S));
    in_track = TW'(32'(in_pat) * NUM_INSTRUMENTS + 32'(in_instr));
  end

  // Split the fetched row and build the modified one for a write
  always_comb begin
    idx      = step_q[SW-1:0];
    row_act  = rd_q[S-1:0];
    row_mute = rd_q[2*S-1:S];
    row_vel  = rd_q[RowW-1:2*S];
    new_act  = row_act;
    new_mute = row_mute;
    new_vel  = row_vel;
    new_act[idx]                 = wr_active_q;
    new_mute[idx]                = wr_mute_q;
    new_vel[{idx, 3'b000} +: 8]  = wr_vel_q;
    find_start = (32'(step_q) >= S) ? '0 : step_q[SW-1:0];
  end

  // Memory write port: clearing pass or write-back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = track_q;
    wr_data = {new_vel, new_mute, new_act};
    find_go = 1'b0;
    unique case (state_q)
      StClear: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
      end
      StRead: begin
        wr_en   = (req_q == dsps_pkg::ReqWrite);
        find_go = (req_q == dsps_pkg::ReqFind);
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Track memory, one row per track
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_accept && !in_bad) begin
      rd_q <= mem[in_track];
    end
  end

  dsps_find #(
    .STEPS_PER_TRACK(STEPS_PER_TRACK)
  ) u_find (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (find_go),
    .start_step_i(find_start),
    .bitmap_i    (row_act),
    .status_o    (find_st)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Fill the output register, or drop the word once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_cnt_q <= clr_cnt_q + TW'(1);
          if (clr_cnt_q == TW'(NT - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_accept) begin
            req_q       <= in_req;
            track_q     <= in_track;
            step_q      <= in_step;
            wr_active_q <= s_axis_tdata[15];
            wr_mute_q   <= s_axis_tdata[16];
            wr_vel_q    <= s_axis_tdata[24:17];
            if (in_bad) begin
              res_found_q  <= 1'b0;
              res_active_q <= 1'b0;
              res_mute_q   <= 1'b0;
              res_vel_q    <= '0;
              state_q      <= StDone;
            end else begin
              state_q <= StRead;
            end
          end
        end
        StRead: begin
          unique case (req_q)
            dsps_pkg::ReqWrite: begin
              res_found_q  <= 1'b1;
              res_active_q <= wr_active_q;
              res_mute_q   <= wr_mute_q;
              res_vel_q    <= wr_vel_q;
              state_q      <= StDone;
            end
            dsps_pkg::ReqFind: begin
              state_q <= StFind;
            end
            default: begin
              state_q <= StExt;
            end
          endcase
        end
        StFind: begin
          if (find_st.done) begin
            if (find_st.hit) begin
              step_q  <= find_st.step;
              state_q <= StExt;
            end else begin
              res_found_q  <= 1'b0;
              res_active_q <= 1'b0;
              res_mute_q   <= 1'b0;
              res_vel_q    <= '0;
              state_q      <= StDone;
            end
          end
        end
        StExt: begin
          res_found_q  <= 1'b1;
          res_active_q <= row_act[idx] || (req_q == dsps_pkg::ReqFind);
          res_mute_q   <= row_mute[idx];
          res_vel_q    <= row_vel[{idx, 3'b000} +: 8];
          state_q      <= StDone;
        end
        StDone: begin
          if (out_load) begin
            out_found_q <= res_found_q;
            out_data_q  <= {res_vel_q, res_mute_q, res_active_q, step_q};
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_found_q;

  // Checks on the sequencer
  `DSPS_ASSERT(a_no_accept_in_clear, (state_q == StClear) |-> !s_axis_tready,
               "request accepted during clearing pass")
  `DSPS_ASSERT_NEXT(a_busy_after_accept, in_accept, (state_q != StIdle),
                    "sequencer stayed idle after a request")
  `DSPS_ASSERT(a_find_done_in_find, find_st.done |-> (state_q == StFind),
               "find unit finished outside a search")
  `DSPS_ASSERT(a_no_write_when_idle, !(wr_en && (state_q == StIdle)),
               "track memory written while idle")

endmodule

### tb/drum_step_pattern_store_top_tb.sv
module drum_step_pattern_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTracks    = dsps_pkg::NumInstruments * dsps_pkg::NumPatterns;
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 16;
  localparam int RandomItems  = 1250;
  localparam int BatchItems   = 125;

  // Request word, packed so the instrument lands in the lowest bits of tdata
  typedef struct packed {
    logic [1:0]                 sub3;
    logic [1:0]                 sub2;
    logic [1:0]                 sub1;
    logic [1:0]                 sub0;
    logic                       mute;
    logic                       active;
    logic [dsps_pkg::StepW-1:0] step;
    logic [5:0]                 pat;
    logic [2:0]                 instr;
  } step_request_t;

  // Result word as carried on m_axis_tdata
  typedef struct packed {
    logic [1:0]                 sub3;
    logic [1:0]                 sub2;
    logic [1:0]                 sub1;
    logic [1:0]                 sub0;
    logic                       mute;
    logic                       active;
    logic [dsps_pkg::StepW-1:0] step;
  } step_word_t;

  typedef struct packed {
    logic       found;
    step_word_t word;
  } step_result_t;

  typedef enum int {RxAlways, RxCoin, RxPeriodic, RxSparse} rx_mode_e;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  drum_step_pattern_store_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Shadow copy of the pattern store
  logic [dsps_pkg::StepsPerTrack-1:0] active_map [NumTracks];
  logic [dsps_pkg::StepsPerTrack-1:0] mute_map   [NumTracks];
  logic [7:0]                         vel_mem    [NumTracks * dsps_pkg::StepsPerTrack];

  step_result_t pending_results[$];

  int errors;
  int cycle_count;
  int burst_left;
  int n_reads, n_writes, n_hits, n_misses, n_unknown, n_checked;

  function automatic step_request_t make_req(int instr, int pat, int step, int act,
                                             int mute, int s0, int s1, int s2, int s3);
    step_request_t rq;
    rq.instr  = instr[2:0];
    rq.pat    = pat[5:0];
    rq.step   = step[dsps_pkg::StepW-1:0];
    rq.active = act[0];
    rq.mute   = mute[0];
    rq.sub0   = s0[1:0];
    rq.sub1   = s1[1:0];
    rq.sub2   = s2[1:0];
    rq.sub3   = s3[1:0];
    return rq;
  endfunction

  function automatic step_result_t stored_step(int track, int s);
    step_result_t res;
    logic [7:0]   vel;
    vel = vel_mem[track * dsps_pkg::StepsPerTrack + s];
    res.found       = 1'b1;
    res.word.step   = s[dsps_pkg::StepW-1:0];
    res.word.active = active_map[track][s];
    res.word.mute   = mute_map[track][s];
    {res.word.sub3, res.word.sub2, res.word.sub1, res.word.sub0} = vel;
    return res;
  endfunction

  // Work out the result of one accepted request and apply any write
  function automatic step_result_t store_access(logic [1:0] kind, step_request_t rq);
    step_result_t res;
    int track;
    int start;
    int s;
    int i;
    res = '0;
    res.word.step = rq.step;
    if (kind == dsps_pkg::ReqUnknown || rq.instr >= dsps_pkg::NumInstruments ||
        rq.pat >= dsps_pkg::NumPatterns) begin
      n_unknown++;
      return res;
    end
    track = int'(rq.pat) * dsps_pkg::NumInstruments + int'(rq.instr);

    // Search forward from the start step, wrapping round the track
    if (kind == dsps_pkg::ReqFind) begin
      start = (rq.step < dsps_pkg::StepsPerTrack) ? int'(rq.step) : 0;
      for (i = 0; i < dsps_pkg::StepsPerTrack; i++) begin
        s = (start + i) % dsps_pkg::StepsPerTrack;
        if (active_map[track][s]) begin
          res = stored_step(track, s);
          res.word.active = 1'b1;
          n_hits++;
          return res;
        end
      end
      n_misses++;
      return res;
    end

    if (rq.step >= dsps_pkg::StepsPerTrack) return res;

    if (kind == dsps_pkg::ReqWrite) begin
      active_map[track][rq.step] = rq.active;
      mute_map[track][rq.step]   = rq.mute;
      vel_mem[track * dsps_pkg::StepsPerTrack + int'(rq.step)] =
        {rq.sub3, rq.sub2, rq.sub1, rq.sub0};
      n_writes++;
    end else begin
      n_reads++;
    end
    return stored_step(track, int'(rq.step));
  endfunction

  // Send one request word; bursts of back-to-back words with random gaps between
  task automatic send_request(logic [1:0] kind, step_request_t rq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 32'(rq);
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(store_access(kind, rq));
    burst_left--;
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each returned word with the oldest expectation
  always @(posedge clk_i) begin
    step_result_t got;
    step_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("found", 8'(want.found), 8'(got.found));
        check_field("out_step", 8'(want.word.step), 8'(got.word.step));
        check_field("out_active", 8'(want.word.active), 8'(got.word.active));
        check_field("out_mute", 8'(want.word.mute), 8'(got.word.mute));
        check_field("out_sub0", 8'(want.word.sub0), 8'(got.word.sub0));
        check_field("out_sub1", 8'(want.word.sub1), 8'(got.word.sub1));
        check_field("out_sub2", 8'(want.word.sub2), 8'(got.word.sub2));
        check_field("out_sub3", 8'(want.word.sub3), 8'(got.word.sub3));
        n_checked++;
      end
    end
  end

  // Receiver back-pressure; a new pattern is drawn at random as rx_tick advances
  int       rx_tick;
  rx_mode_e rx_mode = RxAlways;

  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RxAlways:   m_axis_tready <= 1'b1;
      RxCoin:     m_axis_tready <= 1'($urandom_range(0, 1));
      RxPeriodic: m_axis_tready <= ((rx_tick % 7) >= 3);
      default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic test_cleared_store();
    send_request(dsps_pkg::ReqRead, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqFind, make_req(7, 63, 63, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_write_read_extremes();
    send_request(dsps_pkg::ReqWrite, make_req(7, 63, 63, 1, 1, 3, 3, 3, 3));
    // write fields are don't-care on a read
    send_request(dsps_pkg::ReqRead, make_req(7, 63, 63, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqWrite, make_req(0, 0, 0, 0, 1, 1, 2, 3, 0));
    send_request(dsps_pkg::ReqRead, make_req(0, 0, 0, 1, 1, 3, 3, 3, 3));
    send_request(dsps_pkg::ReqWrite, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_find_wrap();
    send_request(dsps_pkg::ReqWrite, make_req(3, 5, 10, 1, 0, 2, 1, 0, 3));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 10, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 11, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 63, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqWrite, make_req(3, 5, 63, 1, 1, 1, 1, 1, 1));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 11, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 0, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqWrite, make_req(3, 5, 10, 0, 1, 3, 3, 3, 3));
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 0, 0, 0, 0, 0, 0, 0));
    send_request(dsps_pkg::ReqWrite, make_req(3, 5, 63, 0, 0, 2, 2, 2, 2));
    // track now empty: search misses
    send_request(dsps_pkg::ReqFind, make_req(3, 5, 20, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_unknown_kind();
    send_request(dsps_pkg::ReqUnknown, make_req(7, 63, 63, 1, 1, 3, 3, 3, 3));
    send_request(dsps_pkg::ReqUnknown, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0));
    // store must be untouched by the unknown request
    send_request(dsps_pkg::ReqRead, make_req(7, 63, 63, 0, 0, 0, 0, 0, 0));
  endtask

  // Mostly traffic on a few hot tracks, so searches meet written steps
  task automatic test_random_traffic();
    int            hot_instr[4];
    int            hot_pat[4];
    int            pick;
    int            roll;
    int            active_pct;
    logic [1:0]    kind;
    logic [24:0]   raw;
    step_request_t rq;
    for (int h = 0; h < 4; h++) begin
      hot_instr[h] = $urandom_range(0, dsps_pkg::NumInstruments - 1);
      hot_pat[h]   = $urandom_range(0, dsps_pkg::NumPatterns - 1);
    end
    active_pct = 20;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % BatchItems == 0) begin
        if (n > 0) drain_results();
        active_pct = $urandom_range(3, 60);
      end
      raw = 25'($urandom);
      rq  = raw;
      pick = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 7) begin
        rq.instr = hot_instr[pick][2:0];
        rq.pat   = hot_pat[pick][5:0];
      end
      roll = $urandom_range(0, 99);
      if (roll < 40)      kind = dsps_pkg::ReqWrite;
      else if (roll < 65) kind = dsps_pkg::ReqRead;
      else if (roll < 95) kind = dsps_pkg::ReqFind;
      else                kind = dsps_pkg::ReqUnknown;
      if (kind == dsps_pkg::ReqWrite) rq.active = ($urandom_range(0, 99) < active_pct);
      send_request(kind, rq);
    end
  endtask

  initial begin
    for (int t = 0; t < NumTracks; t++) begin
      active_map[t] = '0;
      mute_map[t]   = '0;
    end
    for (int v = 0; v < NumTracks * dsps_pkg::StepsPerTrack; v++) vel_mem[v] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_store();
    test_write_read_extremes();
    test_find_wrap();
    test_unknown_kind();
    drain_results();
    test_random_traffic();
    drain_results();

    $display("run covered %0d reads, %0d writes, %0d search hits, %0d search misses",
             n_reads, n_writes, n_hits, n_misses);
    $display("%0d unknown or bad, %0d result words compared, %0d mismatches",
             n_unknown, n_checked, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/dsps_pkg.sv
hdl/dsps_find.sv
hdl/drum_step_pattern_store_top.sv
tb/drum_step_pattern_store_top_tb.sv
